>>> rtl/cfcp_pkg.sv
// ----------------------------------------------------------------------------
// cfcp_pkg
// shared types, constants and the crc-8 byte update for the frame parser
// ----------------------------------------------------------------------------
package cfcp_pkg;

  localparam logic [7:0] HdrFirst  = 8'h55;
  localparam logic [7:0] HdrSecond = 8'hAA;
  localparam logic [7:0] CmdType   = 8'h05;
  localparam logic [7:0] CrcPoly   = 8'h8C;   // reflected crc-8/maxim polynomial

  // frame index layout: header 0..1, type 2, data 3..8, flag 9, crc 10
  localparam logic [3:0] PosType     = 4'd2;
  localparam logic [3:0] PosDataLast = 4'd8;
  localparam logic [3:0] PosDataFirst = 4'd3;
  localparam logic [3:0] PosCrc      = 4'd10;

  localparam int unsigned NumData = 6;

  typedef enum logic [1:0] {
    ST_HEAD1 = 2'd0,
    ST_HEAD2 = 2'd1,
    ST_BODY  = 2'd2
  } sync_e;

  typedef logic [7:0] byte_t;

  // one byte of reflected crc, eight shift steps
  function automatic byte_t crc8_update(byte_t crc, byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/cfcp_if.sv
// ----------------------------------------------------------------------------
// cfcp stream interfaces
// byte stream into the parser and command stream out of it
// ----------------------------------------------------------------------------
interface cfcp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfcp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic signed [15:0] angle_cmd;

  modport source (output valid, output left_speed, output right_speed,
                  output angle_cmd, input ready);
  modport sink   (input valid, input left_speed, input right_speed,
                  input angle_cmd, output ready);
endinterface

>>> rtl/crc8_framed_command_parser.sv
// ----------------------------------------------------------------------------
// crc8_framed_command_parser
// header-synchronized command frame parser with crc-8/maxim check
// ----------------------------------------------------------------------------
// Takes received bytes one per transfer and hunts for the header 0x55 0xAA,
// then collects nine body bytes (type, six data bytes, flag, crc). The crc
// runs over type, data and flag as they arrive. When the type is 0x05 and the
// received crc matches, one command transfer carries left speed, right speed
// and angle (signed, little endian, frame bytes 3-4, 5-6, 7-8). Bad frames
// give nothing. The block takes one byte every clock cycle; the result of a
// good frame shows on the command channel in the cycle after its crc byte is
// taken. The only thing that holds the byte channel back is the single
// result register: while it holds a command that the sink has not taken,
// rx_i.ready is low, and it goes high again in the cycle the command leaves.
// ----------------------------------------------------------------------------
module crc8_framed_command_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfcp_rx_if.sink       rx_i,
  cfcp_cmd_if.source    cmd_o
);
  import cfcp_pkg::*;

  // parser state
  sync_e       state_q, state_d;
  logic [3:0]  pos_q, pos_d;
  byte_t       crc_q, crc_d;
  logic        type_ok_q, type_ok_d;
  byte_t       data_q [NumData];    // data shift line, byte 3 ends in slot 0
  logic        data_shift;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] left_q, right_q, angle_q;
  logic               emit;

  logic  rx_take;
  byte_t b;

  // byte is taken unless a finished command is stuck in the result register
  assign rx_i.ready = !out_valid_q || cmd_o.ready;
  assign rx_take    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    crc_d      = crc_q;
    type_ok_d  = type_ok_q;
    data_shift = 1'b0;
    emit       = 1'b0;
    if (rx_take) begin
      unique case (state_q)
        ST_HEAD1: begin
          if (b == HdrFirst) state_d = ST_HEAD2;
        end
        ST_HEAD2: begin
          if (b == HdrSecond) begin
            state_d   = ST_BODY;
            pos_d     = PosType;
            crc_d     = '0;
            type_ok_d = 1'b0;
          end else if (b != HdrFirst) begin
            // a repeated 0x55 keeps waiting for 0xaa, anything else restarts
            state_d = ST_HEAD1;
          end
        end
        ST_BODY: begin
          priority if (pos_q < PosType || pos_q > PosCrc) begin
            // lost position: drop the byte and hunt again
            state_d = ST_HEAD1;
            pos_d   = '0;
          end else if (pos_q < PosCrc) begin
            // type, data and flag bytes all feed the crc
            crc_d = crc8_update(crc_q, b);
            if (pos_q == PosType) type_ok_d = (b == CmdType);
            data_shift = (pos_q >= PosDataFirst) && (pos_q <= PosDataLast);
            pos_d = pos_q + 4'd1;
          end else begin
            // crc byte: judge the frame, no resync inside the body
            state_d = ST_HEAD1;
            pos_d   = '0;
            emit    = type_ok_q && (b == crc_q);
          end
        end
        default: begin
          state_d = ST_HEAD1;
          pos_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HEAD1;
      pos_q     <= '0;
      crc_q     <= '0;
      type_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      type_ok_q <= type_ok_d;
    end
  end

  // data bytes shift in from the top; after six shifts byte 3 sits in slot 0
  always_ff @(posedge clk_i) begin
    if (data_shift) begin
      for (int i = 0; i < NumData - 1; i++) begin
        data_q[i] <= data_q[i+1];
      end
      data_q[NumData-1] <= b;
    end
  end

  // result register: loaded on a good frame, held until the sink takes it
  assign out_valid_d = emit || (out_valid_q && !cmd_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      left_q  <= {data_q[1], data_q[0]};
      right_q <= {data_q[3], data_q[2]};
      angle_q <= {data_q[5], data_q[4]};
    end
  end

  assign cmd_o.valid       = out_valid_q;
  assign cmd_o.left_speed  = left_q;
  assign cmd_o.right_speed = right_q;
  assign cmd_o.angle_cmd   = angle_q;

endmodule

>>> rtl/cfcp_checker.sv
// ----------------------------------------------------------------------------
// cfcp_checker
// port-level checks for the framed command parser
// ----------------------------------------------------------------------------
module cfcp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_i,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic [15:0] left_speed_i,
  input logic [15:0] right_speed_i,
  input logic [15:0] angle_cmd_i
);

  // stalled command holds its payload
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !cmd_ready_i |=> cmd_valid_i && $stable(left_speed_i)
      && $stable(right_speed_i) && $stable(angle_cmd_i))
    else $error("stalled command changed");

  // byte channel only stalls behind a stuck command
  a_rx_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> cmd_valid_i && !cmd_ready_i)
    else $error("byte channel stalled without a pending command");

  // a new command only follows a byte transfer
  a_cmd_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd_valid_i) |-> $past(rx_valid_i && rx_ready_i))
    else $error("command appeared without a byte transfer");

  // back-to-back commands also need a byte transfer in between
  a_cmd_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && $past(cmd_valid_i && cmd_ready_i)
      |-> $past(rx_valid_i && rx_ready_i))
    else $error("repeated command without a byte transfer");

endmodule

bind crc8_framed_command_parser cfcp_checker u_cfcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rx_valid_i    (rx_i.valid),
  .rx_ready_i    (rx_i.ready),
  .cmd_valid_i   (cmd_o.valid),
  .cmd_ready_i   (cmd_o.ready),
  .left_speed_i  (cmd_o.left_speed),
  .right_speed_i (cmd_o.right_speed),
  .angle_cmd_i   (cmd_o.angle_cmd)
);

>>> verif/crc8_framed_command_parser_tb.sv
// ----------------------------------------------------------------------------
// crc8_framed_command_parser_tb
// self-checking bench for the header-synchronized crc-8 command parser
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first: header restarts, a bad
// second header byte, extreme command values, 0x55 inside a body and a
// wrong frame type. Random frames with random content follow, mixed with
// noise, broken headers, bad types and bad crcs. A local copy of the
// parser state works out every command that an accepted byte should
// produce, and each command transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module crc8_framed_command_parser_tb;
  import cfcp_pkg::*;

  typedef struct packed {
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic signed [15:0] angle_cmd;
  } cmd_t;

  localparam cmd_t NO_CMD = '0;

  // a table row either carries its byte or takes the running crc
  typedef enum logic {RAW_BYTE, RUNNING_CRC} fill_e;

  typedef struct {
    byte_t value;
    fill_e fill;
    bit    typed;   // expected command written out by hand
    cmd_t  want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cfcp_rx_if  rx_if ();
  cfcp_cmd_if cmd_if ();

  crc8_framed_command_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cmd_o  (cmd_if)
  );

  // 12 unit period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // local parser state, advanced on every accepted byte
  // --------------------------------------------------------------------------
  sync_e  hunt_state;
  logic [3:0] body_pos;
  byte_t  body_crc;
  bit     type_ok;
  byte_t  data_bytes [NumData];

  cmd_t   pending_cmds [$];   // commands still owed by the block
  int     mismatches = 0;

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     holding = 1'b0;     // receiver held off for a long stretch
  event   hold_kick;
  int     frame_bytes = 0;    // bytes sent inside generated frames
  int     frame_count = 0;

  // bitwise reflected crc-8/maxim, one data bit per step
  function automatic byte_t crc_maxim_step(byte_t crc, byte_t data);
    byte_t acc;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ data[i]) acc = (acc >> 1) ^ CrcPoly;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  // feed one byte to the local parser, returns 1 when a command is due
  function automatic bit parse_byte(input byte_t b, output cmd_t cmd);
    cmd = NO_CMD;
    case (hunt_state)
      ST_HEAD1: begin
        if (b == HdrFirst) hunt_state = ST_HEAD2;
      end
      ST_HEAD2: begin
        if (b == HdrSecond) begin
          hunt_state = ST_BODY;
          body_pos   = PosType;
          body_crc   = '0;
          type_ok    = 1'b0;
        end else if (b != HdrFirst) begin
          // anything but a repeated 0x55 drops the header
          hunt_state = ST_HEAD1;
        end
      end
      ST_BODY: begin
        if (body_pos < PosType || body_pos > PosCrc) begin
          hunt_state = ST_HEAD1;
          body_pos   = '0;
        end else if (body_pos < PosCrc) begin
          // type, data and flag are all under the crc, no resync on 0x55
          body_crc = crc_maxim_step(body_crc, b);
          if (body_pos == PosType) type_ok = (b == CmdType);
          else if (body_pos <= PosDataLast)
            data_bytes[3'(body_pos - PosDataFirst)] = b;
          body_pos = body_pos + 4'd1;
        end else begin
          // crc byte: the frame is judged here either way
          hunt_state = ST_HEAD1;
          body_pos   = '0;
          if (type_ok && b == body_crc) begin
            cmd.left_speed  = {data_bytes[1], data_bytes[0]};
            cmd.right_speed = {data_bytes[3], data_bytes[2]};
            cmd.angle_cmd   = {data_bytes[5], data_bytes[4]};
            return 1'b1;
          end
        end
      end
      default: begin
        hunt_state = ST_HEAD1;
        body_pos   = '0;
      end
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // byte sender: called at a falling edge, returns at the falling edge
  // after its transfer
  // --------------------------------------------------------------------------
  task automatic send_byte(input byte_t b, input bit typed = 1'b0,
                           input cmd_t want = NO_CMD);
    cmd_t predicted;
    bit   due;
    if ($urandom_range(99) < send_idle_pct) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    due = parse_byte(b, predicted);
    // hand-written rows override the local parser
    if (typed) pending_cmds.push_back(want);
    else if (due) pending_cmds.push_back(predicted);
    @(negedge clk_i);
  endtask

  // data bytes lean toward the sign and magnitude extremes
  function automatic byte_t pick_data();
    byte_t corners [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(99) < 20) return corners[$urandom_range(3)];
    return byte_t'($urandom_range(255));
  endfunction

  // one frame with random content, sometimes behind noise or a broken
  // header, sometimes with a foreign type or a corrupted crc
  task automatic send_random_frame();
    byte_t crc;
    byte_t b;
    crc = '0;
    if ($urandom_range(99) < 25) begin
      repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(255)));
    end
    if ($urandom_range(99) < 10) begin
      send_byte(HdrFirst);
      do b = byte_t'($urandom_range(255)); while (b == HdrFirst || b == HdrSecond);
      send_byte(b);
    end
    if ($urandom_range(99) < 10) send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    b = ($urandom_range(99) < 85) ? CmdType : byte_t'($urandom_range(255));
    send_byte(b);
    crc = crc_maxim_step(crc, b);
    for (int i = 0; i < NumData; i++) begin
      b = pick_data();
      send_byte(b);
      crc = crc_maxim_step(crc, b);
    end
    b = byte_t'($urandom_range(255));   // flag byte
    send_byte(b);
    crc = crc_maxim_step(crc, b);
    if ($urandom_range(99) < 15) crc = crc ^ byte_t'($urandom_range(1, 255));
    send_byte(crc);
    frame_bytes += 11;
    frame_count++;
  endtask

  // --------------------------------------------------------------------------
  // command sink: random stalls plus an occasional long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    cmd_if.ready <= holding ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // the long hold-off counts its own cycles
  initial begin
    forever begin
      @(hold_kick);
      holding = 1'b1;
      repeat (80) @(negedge clk_i);
      holding = 1'b0;
    end
  end

  // every command transfer is matched against the oldest one owed
  always @(posedge clk_i) begin : cmd_monitor
    cmd_t seen;
    cmd_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      seen = '{cmd_if.left_speed, cmd_if.right_speed, cmd_if.angle_cmd};
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: left %0d right %0d angle %0d",
                   seen.left_speed, seen.right_speed, seen.angle_cmd);
      end else begin
        want = pending_cmds.pop_front();
        if (seen.left_speed !== want.left_speed ||
            seen.right_speed !== want.right_speed ||
            seen.angle_cmd !== want.angle_cmd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("command mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     want.left_speed, want.right_speed, want.angle_cmd,
                     seen.left_speed, seen.right_speed, seen.angle_cmd);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed bytes
  // --------------------------------------------------------------------------
  step_t directed_steps [28] = '{
    // idle bytes while hunting, then a repeated first header byte
    '{8'h00, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hFF, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h55, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h55, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hAA, RAW_BYTE, 1'b0, NO_CMD},
    // good frame: most negative left, most positive right, 0x55 in the body
    '{8'h05, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h00, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h80, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hFF, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h7F, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h55, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hAA, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hFF, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h00, RUNNING_CRC, 1'b1, '{16'h8000, 16'h7FFF, 16'hAA55}},
    // wrong second header byte, then a stray 0xaa that is ignored
    '{8'h55, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h12, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hAA, RAW_BYTE, 1'b0, NO_CMD},
    // frame with a foreign type and a valid crc gives nothing
    '{8'h55, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hAA, RAW_BYTE, 1'b0, NO_CMD},
    '{8'hFF, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h01, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h02, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h03, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h04, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h05, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h06, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h00, RAW_BYTE, 1'b0, NO_CMD},
    '{8'h00, RUNNING_CRC, 1'b0, NO_CMD}
  };

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cmd_if.ready  = 1'b0;
    hunt_state    = ST_HEAD1;
    body_pos      = '0;
    body_crc      = '0;
    type_ok       = 1'b0;
    foreach (data_bytes[i]) data_bytes[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // three idle profiles: sender light and sink heavy, swapped, none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 55 : 0;
      recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 17 : 0;
      if (phase == 0) begin
        foreach (directed_steps[i]) begin
          send_byte((directed_steps[i].fill == RUNNING_CRC) ? body_crc
                                                            : directed_steps[i].value,
                    directed_steps[i].typed, directed_steps[i].want);
        end
      end
      while (frame_bytes < (phase + 1) * 600) begin
        // sink goes quiet while frames keep coming, so the input stalls
        if (phase != 1 && frame_count % 160 == 20) -> hold_kick;
        send_random_frame();
      end
      // sender drains everything owed before the next profile
      rx_if.valid <= 1'b0;
      wait (pending_cmds.size() == 0);
      @(negedge clk_i);
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
